// ----- design/rect_pkg.sv -----
// Shared types and defaults for the rectangle overlap merge block.
// No dependencies; used by rect_ctrl, rect_dp and rectangle_overlap_merge.
package rect_pkg;

   localparam int DEFAULT_MAX_REGIONS = 32;
   localparam int DEFAULT_COORD_BITS  = 13;

   // controller states
   typedef enum logic [2:0] {
      S_LOAD,   // collecting rectangles
      S_IPICK,  // pick next kept slot i
      S_ILOAD,  // slot i data arrives, latch into accumulator
      S_JSCAN,  // stream later slots j against the accumulator
      S_IWB,    // write the grown box back to slot i
      S_EPICK,  // pick next survivor to send
      S_EWAIT,  // survivor data arrives
      S_EOUT    // result transaction waiting
   } rect_state_type;

   // controller -> datapath
   typedef struct packed {
      logic store;       // input transaction accepted
      logic i_clear;     // slot index and survivor index back to zero
      logic i_inc;       // advance slot index
      logic read_i;      // read store at slot index
      logic acc_load;    // accumulator <= read data, start scan at i+1
      logic scan;        // one scan step
      logic write_back;  // accumulator -> store at slot index
      logic out_load;    // output registers <= read data
      logic finish;      // set is done, clear count and overflow flag
   } rect_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic i_end;       // slot index reached the fill count
      logic i_alive;     // slot at index has not been merged away
      logic scan_done;   // scan issued and compared every later slot
      logic out_last;    // held result is the last of the set
   } rect_status_type;

endpackage

// ----- design/rect_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rect_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rect_ctrl.sv -----
// Controller state machine for the rectangle overlap merge block.
// Depends on rect_pkg; drives rect_dp through rect_cmd_type.
module rect_ctrl import rect_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last_in,
   output logic            req_ready,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   input  rect_status_type status,
   output rect_cmd_type    cmd
);

   rect_state_type state_ff;
   rect_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_valid && req_last_in) state_in = S_IPICK;
         end
         S_IPICK: begin
            if (status.i_end)        state_in = S_EPICK;
            else if (status.i_alive) state_in = S_ILOAD;
         end
         S_ILOAD: state_in = S_JSCAN;
         S_JSCAN: begin
            if (status.scan_done) state_in = S_IWB;
         end
         S_IWB:   state_in = S_IPICK;
         S_EPICK: begin
            if (status.i_end)        state_in = S_LOAD;
            else if (status.i_alive) state_in = S_EWAIT;
         end
         S_EWAIT: state_in = S_EOUT;
         S_EOUT: begin
            if (rsp_ready) state_in = status.out_last ? S_LOAD : S_EPICK;
         end
         default: state_in = S_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready   = 1'b1;
            cmd.store   = req_valid;
            cmd.i_clear = req_valid && req_last_in;
         end
         S_IPICK: begin
            if (status.i_end)        cmd.i_clear = 1'b1;
            else if (status.i_alive) cmd.read_i  = 1'b1;
            else                     cmd.i_inc   = 1'b1;
         end
         S_ILOAD: cmd.acc_load = 1'b1;
         S_JSCAN: cmd.scan     = 1'b1;
         S_IWB: begin
            cmd.write_back = 1'b1;
            cmd.i_inc      = 1'b1;
         end
         S_EPICK: begin
            if (status.i_end)        cmd.finish = 1'b1;
            else if (status.i_alive) cmd.read_i = 1'b1;
            else                     cmd.i_inc  = 1'b1;
         end
         S_EWAIT: cmd.out_load = 1'b1;
         S_EOUT: begin
            rsp_valid  = 1'b1;
            cmd.finish = rsp_ready && status.out_last;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- design/rect_dp.sv -----
// Datapath: region store, alive flags, slot/scan counters, accumulator, output regs.
// Depends on rect_pkg and rect_ram; commanded by rect_ctrl.
module rect_dp import rect_pkg::*; #(
   parameter int MAX_REGIONS = DEFAULT_MAX_REGIONS,
   parameter int COORD_BITS  = DEFAULT_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rect_cmd_type          cmd,
   output rect_status_type       status,
   input  logic [COORD_BITS-1:0] req_in_x_low,
   input  logic [COORD_BITS-1:0] req_in_y_low,
   input  logic [COORD_BITS-1:0] req_in_x_high,
   input  logic [COORD_BITS-1:0] req_in_y_high,
   output logic [COORD_BITS-1:0] rsp_out_x_low,
   output logic [COORD_BITS-1:0] rsp_out_y_low,
   output logic [COORD_BITS-1:0] rsp_out_x_high,
   output logic [COORD_BITS-1:0] rsp_out_y_high,
   output logic                  rsp_last_region,
   output logic                  rsp_overflowed
);

   localparam int IDX_BITS = $clog2(MAX_REGIONS);
   localparam int CNT_BITS = $clog2(MAX_REGIONS + 1);
   localparam int BOX_BITS = 4 * COORD_BITS;
   localparam logic [CNT_BITS-1:0] ONE_CNT  = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(MAX_REGIONS);

   // box layout: {x_low, y_low, x_high, y_high}
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    surv_ff, surv_in;
   logic                   ovf_ff, ovf_in;
   logic [MAX_REGIONS-1:0] alive_ff, alive_in;
   logic [CNT_BITS-1:0]    i_ff, i_in;
   logic [CNT_BITS-1:0]    j_ff, j_in;
   logic                   pend_ff, pend_in;
   logic [IDX_BITS-1:0]    pidx_ff, pidx_in;
   logic [BOX_BITS-1:0]    acc_ff, acc_in;
   logic [BOX_BITS-1:0]    out_ff, out_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_ovf_ff, out_ovf_in;

   logic                   room;
   logic                   j_end;
   logic                   hit;
   logic [BOX_BITS-1:0]    rd_data;
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [BOX_BITS-1:0]    wr_data;
   logic                   rd_en;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [COORD_BITS-1:0]  a_xl, a_yl, a_xh, a_yh;
   logic [COORD_BITS-1:0]  b_xl, b_yl, b_xh, b_yh;
   logic [BOX_BITS-1:0]    union_box;

   assign room  = count_ff < FULL_CNT;
   assign j_end = j_ff >= count_ff;

   assign a_xl = acc_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign a_yl = acc_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign a_xh = acc_ff[2*COORD_BITS-1:COORD_BITS];
   assign a_yh = acc_ff[COORD_BITS-1:0];
   assign b_xl = rd_data[4*COORD_BITS-1:3*COORD_BITS];
   assign b_yl = rd_data[3*COORD_BITS-1:2*COORD_BITS];
   assign b_xh = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign b_yh = rd_data[COORD_BITS-1:0];

   // strict overlap: shared edges don't count
   assign hit = pend_ff && alive_ff[pidx_ff] &&
                (a_xl < b_xh) && (b_xl < a_xh) && (a_yl < b_yh) && (b_yl < a_yh);

   assign union_box = {(a_xl < b_xl) ? a_xl : b_xl,
                       (a_yl < b_yl) ? a_yl : b_yl,
                       (a_xh > b_xh) ? a_xh : b_xh,
                       (a_yh > b_yh) ? a_yh : b_yh};

   // store port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_BITS-1:0];
      wr_data = {req_in_x_low, req_in_y_low, req_in_x_high, req_in_y_high};
      if (cmd.store && room) begin
         wr_en = 1'b1;
      end else if (cmd.write_back) begin
         wr_en   = 1'b1;
         wr_addr = i_ff[IDX_BITS-1:0];
         wr_data = acc_ff;
      end
   end

   assign rd_en   = cmd.read_i || (cmd.scan && !j_end);
   assign rd_addr = cmd.read_i ? i_ff[IDX_BITS-1:0] : j_ff[IDX_BITS-1:0];

   rect_ram #(
      .WIDTH (BOX_BITS),
      .DEPTH (MAX_REGIONS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in    = count_ff;
      surv_in     = surv_ff;
      ovf_in      = ovf_ff;
      alive_in    = alive_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      acc_in      = acc_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;

      if (cmd.store) begin
         if (room) begin
            alive_in[count_ff[IDX_BITS-1:0]] = 1'b1;
            count_in = count_ff + ONE_CNT;
            surv_in  = surv_ff + ONE_CNT;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.i_clear) begin
         i_in = '0;
         j_in = '0;
      end
      if (cmd.i_inc) begin
         i_in = i_ff + ONE_CNT;
      end
      if (cmd.acc_load) begin
         acc_in = rd_data;
         j_in   = i_ff + ONE_CNT;
      end
      if (cmd.scan) begin
         // issue stage
         if (!j_end) begin
            pend_in = 1'b1;
            pidx_in = j_ff[IDX_BITS-1:0];
            j_in    = j_ff + ONE_CNT;
         end
         // compare stage
         if (hit) begin
            acc_in            = union_box;
            alive_in[pidx_ff] = 1'b0;
            surv_in           = surv_ff - ONE_CNT;
         end
      end
      if (cmd.out_load) begin
         out_in      = rd_data;
         out_last_in = (j_ff + ONE_CNT) == surv_ff;
         out_ovf_in  = ovf_ff;
         i_in        = i_ff + ONE_CNT;
         j_in        = j_ff + ONE_CNT;
      end
      if (cmd.finish) begin
         count_in = '0;
         surv_in  = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         surv_ff  <= '0;
         ovf_ff   <= 1'b0;
         alive_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         surv_ff  <= surv_in;
         ovf_ff   <= ovf_in;
         alive_ff <= alive_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      acc_ff      <= acc_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign status.i_end     = i_ff >= count_ff;
   assign status.i_alive   = alive_ff[i_ff[IDX_BITS-1:0]];
   assign status.scan_done = j_end && !pend_ff;
   assign status.out_last  = out_last_ff;

   assign rsp_out_x_low   = out_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign rsp_out_y_low   = out_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign rsp_out_x_high  = out_ff[2*COORD_BITS-1:COORD_BITS];
   assign rsp_out_y_high  = out_ff[COORD_BITS-1:0];
   assign rsp_last_region = out_last_ff;
   assign rsp_overflowed  = out_ovf_ff;

endmodule

// ----- design/rectangle_overlap_merge.sv -----
// Rectangle overlap merge, top level: controller plus datapath.
// Depends on rect_pkg, rect_ctrl, rect_dp (which holds rect_ram).
//
// Loads up to MAX_REGIONS axis-aligned rectangles, one per req transaction,
// into a single-port-read store; further rectangles are dropped and the set
// is flagged as overflowed. The transaction with req_last_in set (stored or
// dropped) starts a single-pass merge: each surviving slot i in order is
// latched into an accumulator and every later surviving slot j is streamed
// past it, one slot per cycle. Strictly overlapping rectangles (touching
// edges do not count) are folded into the accumulator's bounding box and the
// later slot is marked dead, which gives the same order as removing it and
// compacting. The grown box is written back, then survivors are sent in slot
// order on rsp, the last one with rsp_last_region set and rsp_overflowed on
// all of them. Rectangles are accepted one per cycle while loading; the
// merge streams every later slot past each surviving slot, its length set
// by the one read port of the store; emit skips dead slots and waits on
// rsp_ready for each result. Input is accepted only while loading; during
// merge and emit req_ready is low.
module rectangle_overlap_merge import rect_pkg::*; #(
   parameter int MAX_REGIONS = DEFAULT_MAX_REGIONS,
   parameter int COORD_BITS  = DEFAULT_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_in_x_low,
   input  logic [COORD_BITS-1:0] req_in_y_low,
   input  logic [COORD_BITS-1:0] req_in_x_high,
   input  logic [COORD_BITS-1:0] req_in_y_high,
   input  logic                  req_last_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_out_x_low,
   output logic [COORD_BITS-1:0] rsp_out_y_low,
   output logic [COORD_BITS-1:0] rsp_out_x_high,
   output logic [COORD_BITS-1:0] rsp_out_y_high,
   output logic                  rsp_last_region,
   output logic                  rsp_overflowed
);

   rect_cmd_type    cmd;
   rect_status_type status;

   // sequencing: load, merge pass, emit
   rect_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last_in (req_last_in),
      .req_ready   (req_ready),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .status      (status),
      .cmd         (cmd)
   );

   // store, overlap compare, union and result registers
   rect_dp #(
      .MAX_REGIONS (MAX_REGIONS),
      .COORD_BITS  (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_in_x_low    (req_in_x_low),
      .req_in_y_low    (req_in_y_low),
      .req_in_x_high   (req_in_x_high),
      .req_in_y_high   (req_in_y_high),
      .rsp_out_x_low   (rsp_out_x_low),
      .rsp_out_y_low   (rsp_out_y_low),
      .rsp_out_x_high  (rsp_out_x_high),
      .rsp_out_y_high  (rsp_out_y_high),
      .rsp_last_region (rsp_last_region),
      .rsp_overflowed  (rsp_overflowed)
   );

   // loading and emitting never overlap
   a_no_load_during_emit: assert property (@(posedge clock)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid high together");

   // after reset the block is ready to load
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not loading after reset");

   // a non-final result transaction keeps the block in the emit phase
   a_emit_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_region) |=> !req_ready)
      else $error("load reopened before the last result");

   // the final result transaction hands the block back to loading
   a_load_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_region) |=> (req_ready && !rsp_valid))
      else $error("block not loading after the last result");

endmodule

// ----- dv/rectangle_overlap_merge_tb.sv -----
`timescale 1ns / 1ps
// Testbench for rectangle_overlap_merge: directed and random rectangle sets, with a
// scoreboard class that predicts the single-pass merge. Depends on rect_pkg and the design.

typedef struct packed {
   logic [rect_pkg::DEFAULT_COORD_BITS-1:0] xl;
   logic [rect_pkg::DEFAULT_COORD_BITS-1:0] yl;
   logic [rect_pkg::DEFAULT_COORD_BITS-1:0] xh;
   logic [rect_pkg::DEFAULT_COORD_BITS-1:0] yh;
} rect_box_type;

typedef struct packed {
   rect_box_type box;
   logic         last_region;
   logic         overflowed;
} merged_rect_type;

// Holds the loaded set and the merged rectangles still owed by the design.
class merge_scoreboard;
   rect_box_type    slots[rect_pkg::DEFAULT_MAX_REGIONS];
   int unsigned     fill;
   bit              dropped;
   merged_rect_type survivors_q[$];
   int unsigned     mismatches;

   function new();
      fill       = 0;
      dropped    = 0;
      mismatches = 0;
   endfunction

   function int pending();
      return survivors_q.size();
   endfunction

   // strict test: shared edges do not count
   static function bit strictly_overlap(rect_box_type a, rect_box_type b);
      return (a.xl < b.xh) && (b.xl < a.xh) && (a.yl < b.yh) && (b.yl < a.yh);
   endfunction

   // single pass: slot i absorbs later slots, removed slot position is rechecked
   function void fold_set();
      rect_box_type    work[$];
      rect_box_type    u;
      merged_rect_type m;
      int              i;
      int              j;
      for (i = 0; i < int'(fill); i++) work = {work, slots[i]};
      i = 0;
      while (i < work.size()) begin
         j = i + 1;
         while (j < work.size()) begin
            if (strictly_overlap(work[i], work[j])) begin
               u    = work[i];
               u.xl = (work[j].xl < u.xl) ? work[j].xl : u.xl;
               u.yl = (work[j].yl < u.yl) ? work[j].yl : u.yl;
               u.xh = (work[j].xh > u.xh) ? work[j].xh : u.xh;
               u.yh = (work[j].yh > u.yh) ? work[j].yh : u.yh;
               work[i] = u;
               work.delete(j);
            end else begin
               j++;
            end
         end
         i++;
      end
      foreach (work[k]) begin
         m.box         = work[k];
         m.last_region = (k == work.size() - 1);
         m.overflowed  = dropped;
         survivors_q   = {survivors_q, m};
      end
      fill    = 0;
      dropped = 0;
   endfunction

   function void note_input(rect_box_type r, logic last);
      if (fill < rect_pkg::DEFAULT_MAX_REGIONS) begin
         slots[fill] = r;
         fill++;
      end else begin
         dropped = 1;
      end
      if (last) fold_set();
   endfunction

   function void check_result(merged_rect_type got);
      merged_rect_type want;
      if (survivors_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: xl=%0d yl=%0d xh=%0d yh=%0d last=%0b ovf=%0b",
                     got.box.xl, got.box.yl, got.box.xh, got.box.yh,
                     got.last_region, got.overflowed);
         return;
      end
      want = survivors_q.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"result mismatch: expected xl=%0d yl=%0d xh=%0d yh=%0d last=%0b ovf=%0b",
                      " got xl=%0d yl=%0d xh=%0d yh=%0d last=%0b ovf=%0b"},
                     want.box.xl, want.box.yl, want.box.xh, want.box.yh,
                     want.last_region, want.overflowed,
                     got.box.xl, got.box.yl, got.box.xh, got.box.yh,
                     got.last_region, got.overflowed);
      end
   endfunction
endclass

module rectangle_overlap_merge_tb;
   import rect_pkg::*;

   localparam int CB             = DEFAULT_COORD_BITS;
   localparam int CAPACITY       = DEFAULT_MAX_REGIONS;
   // a full 32-entry merge runs with no transaction; stalls add tails
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASE_ITEMS    = 125;
   localparam logic [CB-1:0] CMAX = '1;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [CB-1:0] req_in_x_low;
   logic [CB-1:0] req_in_y_low;
   logic [CB-1:0] req_in_x_high;
   logic [CB-1:0] req_in_y_high;
   logic          req_last_in;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [CB-1:0] rsp_out_x_low;
   logic [CB-1:0] rsp_out_y_low;
   logic [CB-1:0] rsp_out_x_high;
   logic [CB-1:0] rsp_out_y_high;
   logic          rsp_last_region;
   logic          rsp_overflowed;

   merge_scoreboard sb = new();

   int unsigned  send_idle_pct;   // chance per transaction slot that the sender holds off
   int unsigned  rsp_stall_pct;   // chance per cycle that the receiver stalls
   int unsigned  idle_cycles;     // watchdog: cycles with no transaction on either side
   rect_box_type prev_box;        // last box sent, used to build shared edges

   rectangle_overlap_merge dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_x_low    (req_in_x_low),
      .req_in_y_low    (req_in_y_low),
      .req_in_x_high   (req_in_x_high),
      .req_in_y_high   (req_in_y_high),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x_low   (rsp_out_x_low),
      .rsp_out_y_low   (rsp_out_y_low),
      .rsp_out_x_high  (rsp_out_x_high),
      .rsp_out_y_high  (rsp_out_y_high),
      .rsp_last_region (rsp_last_region),
      .rsp_overflowed  (rsp_overflowed)
   );

   always #6 clock = ~clock;

   // Receiver: random stalls per cycle, driven at the edge like every input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: samples both channels at the edge (pre-edge values, since all
   // drivers use nonblocking updates), feeds the scoreboard, runs the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            sb.note_input({req_in_x_low, req_in_y_low, req_in_x_high, req_in_y_high},
                          req_last_in);
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_out_x_low, rsp_out_y_low, rsp_out_x_high, rsp_out_y_high,
                             rsp_last_region, rsp_overflowed});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // One request transaction. Idle slots drop valid first; once raised, valid
   // and payload hold until the design takes the rectangle.
   task automatic send_rect(input rect_box_type r, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_x_low  <= r.xl;
      req_in_y_low  <= r.yl;
      req_in_x_high <= r.xh;
      req_in_y_high <= r.yh;
      req_last_in   <= last;
      do @(posedge clock); while (!req_ready);
      prev_box = r;
   endtask

   // Sender holds off until every merged rectangle owed so far has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly clustered boxes around a per-set center so merges actually happen;
   // the rest are shared edges, wide random, inverted corners and extremes.
   function automatic rect_box_type pick_box(input logic [CB-1:0] cx,
                                             input logic [CB-1:0] cy,
                                             input rect_box_type prev);
      rect_box_type b;
      int unsigned  mode;
      mode = $urandom_range(99);
      if (mode < 65) begin
         b.xl = cx + CB'($urandom_range(48));
         b.yl = cy + CB'($urandom_range(48));
         b.xh = b.xl + CB'($urandom_range(40));
         b.yh = b.yl + CB'($urandom_range(40));
      end else if (mode < 75) begin
         // abuts the previous box on its right or top edge
         b = prev;
         if ($urandom_range(1)) begin
            b.xl = prev.xh;
            b.xh = prev.xh + CB'($urandom_range(30));
         end else begin
            b.yl = prev.yh;
            b.yh = prev.yh + CB'($urandom_range(30));
         end
      end else if (mode < 85) begin
         b.xl = CB'($urandom);
         b.yl = CB'($urandom);
         b.xh = CB'($urandom);
         b.yh = CB'($urandom);
      end else if (mode < 93) begin
         // low corner above high corner on x, y random
         b.xl = CB'($urandom_range(CMAX, 1));
         b.xh = CB'($urandom_range(b.xl - 1));
         b.yl = CB'($urandom);
         b.yh = CB'($urandom);
      end else begin
         b.xl = $urandom_range(1) ? CMAX : '0;
         b.yl = $urandom_range(1) ? CMAX : '0;
         b.xh = $urandom_range(1) ? CMAX : '0;
         b.yh = $urandom_range(1) ? CMAX : '0;
      end
      return b;
   endfunction

   task automatic send_set(input int unsigned n);
      logic [CB-1:0] cx;
      logic [CB-1:0] cy;
      cx = CB'($urandom);
      cy = CB'($urandom);
      for (int unsigned k = 0; k < n; k++) send_rect(pick_box(cx, cy, prev_box), k == n - 1);
   endtask

   int unsigned phase_sent;
   int unsigned set_len;
   int unsigned size_roll;
   int unsigned full_len[4] = '{33, 32, 36, 34};

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_x_low  = '0;
      req_in_y_low  = '0;
      req_in_x_high = '0;
      req_in_y_high = '0;
      req_last_in   = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      prev_box      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed sets ---
      // one rectangle spanning the whole plane
      send_rect('{0, 0, CMAX, CMAX}, 1'b1);
      // edges touching in x and in y: nothing merges
      send_rect('{0, 0, 10, 10}, 1'b0);
      send_rect('{10, 0, 20, 10}, 1'b0);
      send_rect('{0, 10, 10, 20}, 1'b1);
      // slot 0 grows over a slot it already passed, which stays separate
      send_rect('{0, 0, 10, 10}, 1'b0);
      send_rect('{20, 20, 30, 30}, 1'b0);
      send_rect('{5, 5, 25, 25}, 1'b1);
      // single pass: grown slot 0 is not rescanned against an earlier j
      send_rect('{0, 0, 10, 10}, 1'b0);
      send_rect('{20, 0, 30, 10}, 1'b0);
      send_rect('{12, 0, 22, 10}, 1'b0);
      send_rect('{5, 0, 14, 10}, 1'b1);
      // inverted corners still pass the strict test and union unchanged
      send_rect('{200, 200, 100, 100}, 1'b0);
      send_rect('{0, 0, 300, 300}, 1'b1);
      // extremes and a zero-size box
      send_rect('{CMAX, CMAX, CMAX, CMAX}, 1'b0);
      send_rect('{0, 0, CMAX, CMAX}, 1'b0);
      send_rect('{0, 0, 0, 0}, 1'b1);
      wait_drained();

      // --- random phases: no idling, sender idle, receiver stall, both ---
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 85; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 85; end
            default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         // each phase opens with a full or overfull set; the last mark may be dropped
         send_set(full_len[p]);
         phase_sent = full_len[p];
         while (phase_sent < PHASE_ITEMS) begin
            size_roll = $urandom_range(99);
            if (size_roll < 70)      set_len = $urandom_range(6, 1);
            else if (size_roll < 92) set_len = $urandom_range(16, 7);
            else                     set_len = $urandom_range(30, 17);
            send_set(set_len);
            phase_sent += set_len;
            if ($urandom_range(7) == 0) wait_drained();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/rect_pkg.sv
design/rect_ram.sv
design/rect_ctrl.sv
design/rect_dp.sv
design/rectangle_overlap_merge.sv
dv/rectangle_overlap_merge_tb.sv
